// ----- rtl/smpp_pkg.sv -----
// Shared types and constants for the star map point plotter.
// No dependencies; the channel interfaces and the top level import this package.
`timescale 1ns / 1ps

package smpp_pkg;

	// Largest image side that is still plotted.
	localparam int MAX_DIM_DEF = 4096;

	// Quotient and root bits produced by the serial divide and square root units.
	localparam int ITER_STEPS = 16;
	localparam int STEP_W     = $clog2(ITER_STEPS);

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 25;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RA_LOW       = 3'd0,
		REG_RA_HIGH      = 3'd1,
		REG_DEC_LOW      = 3'd2,
		REG_DEC_HIGH     = 3'd3,
		REG_FAINT_LIMIT  = 3'd4,
		REG_IMAGE_WIDTH  = 3'd5,
		REG_IMAGE_HEIGHT = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_SCAN  = 2'd0,
		OP_PLOT  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	localparam logic        [24:0] RA_LOW_RST       = 25'd0;
	localparam logic        [24:0] RA_HIGH_RST      = 25'd23592960;
	localparam logic signed [23:0] DEC_LOW_RST      = -24'sd5898240;
	localparam logic signed [23:0] DEC_HIGH_RST     = 24'sd5898240;
	localparam logic signed [15:0] FAINT_LIMIT_RST  = 16'sd6000;
	localparam logic        [12:0] IMAGE_WIDTH_RST  = 13'd800;
	localparam logic        [12:0] IMAGE_HEIGHT_RST = 13'd600;

	typedef struct packed {
		logic        [1:0]  op;
		logic        [24:0] right_ascension;
		logic signed [23:0] declination;
		logic signed [15:0] magnitude;
	} star_t;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [7:0]  brightness;
	} plot_t;

endpackage

// ----- rtl/smpp_star_if.sv -----
// Valid/ready channel that carries one star per transaction.
// Depends on smpp_pkg for the star payload type.
`timescale 1ns / 1ps

interface smpp_star_if;
	import smpp_pkg::*;

	logic  valid;
	logic  ready;
	star_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/smpp_plot_if.sv -----
// Valid/ready channel that carries one plotted pixel per transaction.
// Depends on smpp_pkg for the pixel payload type.
`timescale 1ns / 1ps

interface smpp_plot_if;
	import smpp_pkg::*;

	logic  valid;
	logic  ready;
	plot_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/star_map_point_plotter_top.sv -----
// Star map point plotter top level; depends on smpp_pkg, smpp_star_if and smpp_plot_if.
// A counting plot-pass star runs through setup and multiply, 16 divide steps, 16 square root
// steps, the product and the finish state; its pixel, if inside the image, is then offered.
// That star holds the input until it is done, even when it falls outside the image, and
// longer while an earlier pixel waits at the output. Other stars are taken while it stays idle.
// Reset (arst_n low) restores the register defaults, clears the range and the output.
`timescale 1ns / 1ps

module star_map_point_plotter_top #(
	parameter int MAX_DIM = smpp_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [smpp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [smpp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	smpp_star_if.sink                         stars,
	smpp_plot_if.source                       plots
);
	import smpp_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MUL    = 6'b000010,
		ST_DIV    = 6'b000100,
		ST_SQRT   = 6'b001000,
		ST_PROD   = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q;
	logic [STEP_W-1:0] step_q;
	logic last_step;

	// Configuration registers
	logic        [24:0] ra_low_q, ra_high_q;
	logic signed [23:0] dec_low_q, dec_high_q;
	logic signed [15:0] faint_limit_q;
	logic        [12:0] width_q, height_q;

	// Tracked magnitude range
	logic signed [15:0] bright_q, faint_seen_q;
	logic               any_q;

	// Star fields and window test
	logic        [24:0] ra_in;
	logic signed [23:0] dec_in;
	logic signed [15:0] mag_in;
	logic               star_acc, counts, spans_ok;
	logic        [24:0] rspan;
	logic        [24:0] dspan_full;
	logic        [23:0] dspan;
	logic        [24:0] offx_w;
	logic        [24:0] offy_full;
	logic signed [16:0] rng_w, num_w;

	// Datapath registers
	logic [24:0] offx_q;
	logic [23:0] offy_q;
	logic [15:0] rng_q;
	logic        full_q;
	logic [24:0] remx_q;
	logic [15:0] dqx_q;
	logic [23:0] remy_q;
	logic [15:0] dqy_q;
	logic [15:0] remn_q;
	logic [15:0] dqn_q;
	logic [31:0] sv_q;
	logic [17:0] sr_q;
	logic [15:0] sq_q;
	logic [15:0] n2_q;
	logic [15:0] p_q;

	// Output register
	logic        out_valid_q;
	logic [11:0] out_x_q, out_y_q;
	logic [7:0]  out_b_q;

	// Step results
	logic [37:0] px;
	logic [36:0] py;
	logic [25:0] tx;
	logic        gex;
	logic [24:0] remx_nx;
	logic [24:0] ty;
	logic        gey;
	logic [23:0] remy_nx;
	logic [16:0] tn;
	logic        gen;
	logic [15:0] remn_nx;
	logic [15:0] dqn_nx;
	logic [19:0] ts, trial;
	logic        ges;
	logic [31:0] nsq, prod;
	logic [23:0] bsc;
	logic        plot_ok, out_free, load_out;

	assign ra_in    = stars.payload.right_ascension;
	assign dec_in   = stars.payload.declination;
	assign mag_in   = stars.payload.magnitude;
	assign star_acc = stars.valid && stars.ready;

	assign counts = (ra_in >= ra_low_q) && (ra_in <= ra_high_q) &&
			(dec_in >= dec_low_q) && (dec_in <= dec_high_q) &&
			(mag_in <= faint_limit_q);

	// With a counting star the window is not inverted, so both spans and offsets
	// are non-negative and fit their unsigned widths.
	assign rspan      = ra_high_q - ra_low_q;
	assign dspan_full = {dec_high_q[23], dec_high_q} - {dec_low_q[23], dec_low_q};
	assign dspan      = dspan_full[23:0];
	assign offx_w     = ra_in - ra_low_q;
	assign offy_full  = {dec_in[23], dec_in} - {dec_low_q[23], dec_low_q};
	assign spans_ok   = (rspan != '0) && (dspan != '0);

	assign rng_w = {faint_seen_q[15], faint_seen_q} - {bright_q[15], bright_q};
	assign num_w = {faint_seen_q[15], faint_seen_q} - {mag_in[15], mag_in};

	assign last_step = (step_q == STEP_W'(ITER_STEPS - 1));

	always_comb begin
		px = 38'(offx_q) * 38'(width_q);
		py = 37'(offy_q) * 37'(height_q);

		// Restoring division steps, one quotient bit per cycle for each unit.
		tx      = {remx_q, dqx_q[15]};
		gex     = (tx >= {1'b0, rspan});
		remx_nx = gex ? 25'(tx - {1'b0, rspan}) : tx[24:0];

		ty      = {remy_q, dqy_q[15]};
		gey     = (ty >= {1'b0, dspan});
		remy_nx = gey ? 24'(ty - {1'b0, dspan}) : ty[23:0];

		tn      = {remn_q, 1'b0};
		gen     = (tn >= {1'b0, rng_q});
		remn_nx = gen ? 16'(tn - {1'b0, rng_q}) : tn[15:0];
		dqn_nx  = {dqn_q[14:0], gen};

		// Square root, one root bit per cycle from two radicand bits.
		ts    = {sr_q, sv_q[31:30]};
		trial = {2'b00, sq_q, 2'b01};
		ges   = (ts >= trial);

		nsq  = 32'(dqn_q) * 32'(dqn_q);
		prod = 32'(n2_q) * 32'(sq_q);
		bsc  = 24'(p_q) * 24'(8'd255);

		plot_ok = (32'(dqx_q) < 32'(width_q)) && (32'(dqy_q) < 32'(height_q)) &&
				(32'(dqx_q) < 32'(MAX_DIM)) && (32'(dqy_q) < 32'(MAX_DIM));
		out_free = !out_valid_q || plots.ready;
		load_out = (state_q == ST_FINISH) && plot_ok && out_free;
	end

	// Control state, configuration and tracked range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			out_valid_q   <= 1'b0;
			ra_low_q      <= RA_LOW_RST;
			ra_high_q     <= RA_HIGH_RST;
			dec_low_q     <= DEC_LOW_RST;
			dec_high_q    <= DEC_HIGH_RST;
			faint_limit_q <= FAINT_LIMIT_RST;
			width_q       <= IMAGE_WIDTH_RST;
			height_q      <= IMAGE_HEIGHT_RST;
			bright_q      <= '0;
			faint_seen_q  <= '0;
			any_q         <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_RA_LOW:       ra_low_q      <= cfg_wdata[24:0];
					REG_RA_HIGH:      ra_high_q     <= cfg_wdata[24:0];
					REG_DEC_LOW:      dec_low_q     <= cfg_wdata[23:0];
					REG_DEC_HIGH:     dec_high_q    <= cfg_wdata[23:0];
					REG_FAINT_LIMIT:  faint_limit_q <= cfg_wdata[15:0];
					REG_IMAGE_WIDTH:  width_q       <= cfg_wdata[12:0];
					REG_IMAGE_HEIGHT: height_q      <= cfg_wdata[12:0];
					default: ;
				endcase
			end

			// A new pixel may replace one that leaves on the same edge.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (plots.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (star_acc) begin
						if (stars.payload.op == OP_CLEAR) begin
							bright_q     <= '0;
							faint_seen_q <= '0;
							any_q        <= 1'b0;
						end else if (counts && stars.payload.op == OP_SCAN) begin
							if (!any_q) begin
								bright_q     <= mag_in;
								faint_seen_q <= mag_in;
								any_q        <= 1'b1;
							end else begin
								if (mag_in < bright_q) bright_q <= mag_in;
								if (mag_in > faint_seen_q) faint_seen_q <= mag_in;
							end
						end else if (counts && stars.payload.op == OP_PLOT && spans_ok) begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (last_step) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					step_q <= step_q + 1'b1;
					if (last_step) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!plot_ok || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (star_acc) begin
					offx_q <= offx_w;
					offy_q <= offy_full[23:0];
					rng_q  <= rng_w[15:0];
					// Full brightness for an empty range or a star at the bright end.
					full_q <= rng_w[16] || (rng_w == '0) || (num_w >= rng_w);
					remn_q <= (num_w[16] || num_w == '0) ? 16'd0 : num_w[15:0];
					dqn_q  <= '0;
				end
			end
			ST_MUL: begin
				remx_q <= {3'b000, px[37:16]};
				dqx_q  <= px[15:0];
				remy_q <= {3'b000, py[36:16]};
				dqy_q  <= py[15:0];
			end
			ST_DIV: begin
				remx_q <= remx_nx;
				dqx_q  <= {dqx_q[14:0], gex};
				remy_q <= remy_nx;
				dqy_q  <= {dqy_q[14:0], gey};
				remn_q <= remn_nx;
				dqn_q  <= dqn_nx;
				if (last_step) begin
					sv_q <= {dqn_nx, 16'd0};
					sr_q <= '0;
					sq_q <= '0;
				end
			end
			ST_SQRT: begin
				sr_q <= ges ? 18'(ts - trial) : ts[17:0];
				sq_q <= {sq_q[14:0], ges};
				sv_q <= {sv_q[29:0], 2'b00};
				n2_q <= nsq[31:16];
			end
			ST_PROD: begin
				p_q <= prod[31:16];
			end
			ST_FINISH: begin
				if (plot_ok && out_free) begin
					out_x_q <= dqx_q[11:0];
					out_y_q <= dqy_q[11:0];
					out_b_q <= full_q ? 8'd255 : bsc[23:16];
				end
			end
			default: ;
		endcase
	end

	assign stars.ready                = (state_q == ST_IDLE);
	assign plots.valid                = out_valid_q;
	assign plots.payload.pixel_x      = out_x_q;
	assign plots.payload.pixel_y      = out_y_q;
	assign plots.payload.brightness   = out_b_q;

endmodule

// ----- rtl/smpp_checker.sv -----
// Port-level checks for the star map point plotter and the bind that attaches them.
// Depends on star_map_point_plotter_top and its channel interfaces.
`timescale 1ns / 1ps

module smpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        star_valid,
	input logic        star_ready,
	input logic        plot_valid,
	input logic        plot_ready,
	input logic [11:0] plot_x,
	input logic [11:0] plot_y,
	input logic [7:0]  plot_brightness
);

	// A pending pixel stays offered until it is taken.
	a_plot_hold: assert property (@(posedge clk) disable iff (!arst_n)
		plot_valid && !plot_ready |=> plot_valid)
		else $error("plot valid dropped before its transaction");

	a_plot_stable: assert property (@(posedge clk) disable iff (!arst_n)
		plot_valid && !plot_ready |=> $stable({plot_x, plot_y, plot_brightness}))
		else $error("plot payload changed while stalled");

	// A new pixel is loaded only at the end of a star's computation, when no star
	// can be taken.
	a_no_acc_before_plot: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(plot_valid) |-> !$past(star_valid && star_ready))
		else $error("pixel appeared right after a star transaction");

	// Loading a pixel returns the block to idle, so the star channel reopens together.
	a_ready_with_plot: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(plot_valid) |-> $rose(star_ready))
		else $error("star ready did not return with a new pixel");

endmodule

bind star_map_point_plotter_top smpp_checker u_smpp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.star_valid      (stars.valid),
	.star_ready      (stars.ready),
	.plot_valid      (plots.valid),
	.plot_ready      (plots.ready),
	.plot_x          (plots.payload.pixel_x),
	.plot_y          (plots.payload.pixel_y),
	.plot_brightness (plots.payload.brightness)
);
